/* hw/rtl/over_temperature_trip_latch_macros.svh */
// ----------------------------------------------------------------------------
// Over-temperature trip latch assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef OVER_TEMPERATURE_TRIP_LATCH_MACROS_SVH
`define OVER_TEMPERATURE_TRIP_LATCH_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OTL_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("over_temperature_trip_latch: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define OTL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("over_temperature_trip_latch: assertion failed");

`endif

/* hw/rtl/otl_pkg.sv */
// ----------------------------------------------------------------------------
// Over-temperature trip latch package
// Types and constants shared by the trip latch modules.
// ----------------------------------------------------------------------------
package otl_pkg;

    localparam int CARRIED = 4;
    localparam int TEMP_W  = 16;

    localparam logic [15:0] TRIP_RESET  = 16'd1000;
    localparam logic [15:0] REARM_RESET = 16'd900;

    typedef enum logic [2:0] {
        ACT_RESET       = 3'd0,
        ACT_LOCK        = 3'd1,
        ACT_UNLOCK      = 3'd2,
        ACT_DRIVE_FAULT = 3'd3,
        ACT_SAVE_FAULT  = 3'd4,
        ACT_SAVE_OK     = 3'd5,
        ACT_EVALUATE    = 3'd6,
        ACT_ACK         = 3'd7
    } otl_action_t;

    typedef enum logic [2:0] {
        CAUSE_NONE   = 3'd0,
        CAUSE_CONFIG = 3'd1,
        CAUSE_DRIVE  = 3'd2,
        CAUSE_SAVE   = 3'd3,
        CAUSE_SENSOR = 3'd4,
        CAUSE_TEMP   = 3'd5
    } otl_cause_t;

    typedef enum logic {
        REG_TRIP  = 1'b0,
        REG_REARM = 1'b1
    } otl_reg_t;

    typedef struct packed {
        otl_action_t                        action;
        logic [2:0]                         channel_count;
        logic [CARRIED-1:0]                 sample_valid_mask;
        logic [CARRIED-1:0][TEMP_W-1:0]     temperature;
        logic                               scan_done;
    } otl_item_t;

    typedef struct packed {
        logic       latched;
        logic       lock;
        logic       recovered;
        otl_cause_t cause;
        logic [1:0] channel;
    } otl_state_t;

    typedef struct packed {
        logic       ack_accepted;
        logic       output_allowed;
        logic       run_allowed;
        logic       save_retry_ok;
        logic       setpoint_missing;
        logic [1:0] trip_channel;
        otl_cause_t trip_cause;
        logic       trip_latched;
    } otl_result_t;

endpackage

/* hw/rtl/otl_regs.sv */
// ----------------------------------------------------------------------------
// Over-temperature trip latch threshold registers
// APB register file holding the trip and rearm thresholds.
// ----------------------------------------------------------------------------
module otl_regs
    import otl_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output logic [TEMP_W-1:0] trip_threshold,
    output logic [TEMP_W-1:0] rearm_threshold
);

    logic [TEMP_W-1:0] trip_reg;
    logic [TEMP_W-1:0] rearm_reg;
    logic              wr_en;
    otl_reg_t          sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign sel    = otl_reg_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trip_reg  <= TRIP_RESET;
            rearm_reg <= REARM_RESET;
        end
        else if (wr_en)
        begin
            unique case (sel)
                REG_TRIP:  trip_reg  <= pwdata[TEMP_W-1:0];
                REG_REARM: rearm_reg <= pwdata[TEMP_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        unique case (sel)
            REG_TRIP:  prdata = {{(32-TEMP_W){1'b0}}, trip_reg};
            REG_REARM: prdata = {{(32-TEMP_W){1'b0}}, rearm_reg};
            default:   prdata = '0;
        endcase
    end

    assign trip_threshold  = trip_reg;
    assign rearm_threshold = rearm_reg;

endmodule

/* hw/rtl/otl_eval.sv */
// ----------------------------------------------------------------------------
// Over-temperature trip latch evaluation
// Channel compares and next-state logic for one event.
// ----------------------------------------------------------------------------
module otl_eval
    import otl_pkg::*;
#(
    parameter int CHANNELS = 4
)
(
    input  otl_item_t         item,
    input  otl_state_t        state,
    input  logic [TEMP_W-1:0] trip_threshold,
    input  logic [TEMP_W-1:0] rearm_threshold,
    output otl_state_t        state_next,
    output otl_result_t       result
);

    localparam int LIMIT = (CHANNELS < CARRIED) ? CHANNELS : CARRIED;

    logic [2:0]         count_sat;
    logic [CARRIED-1:0] present;
    logic [CARRIED-1:0] offend;
    logic [CARRIED-1:0] not_cool;
    logic [1:0]         first_ch;
    logic               ack_ok;
    logic               temps_cool;

    always_comb
    begin
        count_sat = (item.channel_count > 3'(LIMIT)) ? 3'(LIMIT) : item.channel_count;
        for (int ch = 0; ch < CARRIED; ch++)
        begin
            present[ch]  = 3'(ch) < count_sat;
            offend[ch]   = present[ch] && (!item.sample_valid_mask[ch] ||
                           ($signed(item.temperature[ch]) >= $signed(trip_threshold)));
            not_cool[ch] = present[ch] && (!item.sample_valid_mask[ch] ||
                           ($signed(item.temperature[ch]) > $signed(rearm_threshold)));
        end
        first_ch = '0;
        for (int ch = CARRIED - 1; ch >= 0; ch--)
        begin
            if (offend[ch])
            begin
                first_ch = 2'(ch);
            end
        end
        temps_cool = ~|not_cool;
    end

    always_comb
    begin
        state_next = state;
        ack_ok     = 1'b0;
        unique case (item.action)
            ACT_RESET:
            begin
                state_next = '0;
            end
            ACT_LOCK:
            begin
                state_next.lock    = 1'b1;
                state_next.latched = 1'b1;
                state_next.cause   = CAUSE_CONFIG;
                state_next.channel = '0;
            end
            ACT_UNLOCK:
            begin
                state_next.lock = 1'b0;
            end
            ACT_DRIVE_FAULT:
            begin
                state_next.latched = 1'b1;
                state_next.cause   = CAUSE_DRIVE;
            end
            ACT_SAVE_FAULT:
            begin
                if (!(state.latched && state.cause != CAUSE_SAVE))
                begin
                    state_next.latched   = 1'b1;
                    state_next.cause     = CAUSE_SAVE;
                    state_next.channel   = '0;
                    state_next.recovered = 1'b0;
                end
            end
            ACT_SAVE_OK:
            begin
                if (state.cause == CAUSE_SAVE)
                begin
                    state_next.recovered = 1'b1;
                end
            end
            ACT_EVALUATE:
            begin
                if (!state.latched)
                begin
                    if (count_sat == 3'd0)
                    begin
                        state_next.latched = 1'b1;
                        state_next.cause   = CAUSE_SENSOR;
                        state_next.channel = '0;
                    end
                    else if (|offend)
                    begin
                        state_next.latched = 1'b1;
                        state_next.cause   = item.sample_valid_mask[first_ch] ?
                                             CAUSE_TEMP : CAUSE_SENSOR;
                        state_next.channel = first_ch;
                    end
                end
            end
            ACT_ACK:
            begin
                if (count_sat != 3'd0 && !state.lock && state.cause != CAUSE_DRIVE)
                begin
                    ack_ok = (state.cause == CAUSE_SAVE) ? state.recovered : temps_cool;
                end
                if (ack_ok)
                begin
                    state_next = '0;
                end
            end
            default:
            begin
                state_next = state;
            end
        endcase
    end

    always_comb
    begin
        result.trip_latched     = state_next.latched;
        result.trip_cause       = state_next.cause;
        result.trip_channel     = state_next.channel;
        result.setpoint_missing = state_next.lock;
        result.save_retry_ok    = state_next.recovered;
        result.run_allowed      = !state_next.latched;
        result.output_allowed   = item.scan_done && !state_next.latched;
        result.ack_accepted     = ack_ok;
    end

endmodule

/* hw/rtl/over_temperature_trip_latch.sv */
// ----------------------------------------------------------------------------
// Over-temperature trip latch
// Latched protection interlock for up to four temperature channels.
// ----------------------------------------------------------------------------
// Every request carries one action and returns exactly one status result.
// A request is taken into an input register, evaluated against the latch
// state and the thresholds, and its status lands in a result register;
// one request is taken in every cycle while m_tready does not stall the
// result. The latch state is updated in the same cycle as the result
// register. Thresholds are to be written over the APB port while no
// request is in flight; the block itself does not enforce this.
module over_temperature_trip_latch
    import otl_pkg::*;
#(
    parameter int CHANNELS = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // channel_count[2:0], sample_valid_mask[6:3], temperature_0[22:7],
    // temperature_1[38:23], temperature_2[54:39], temperature_3[70:55],
    // scan_done[71]
    input  logic [71:0] s_tdata,
    // action[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // trip_latched[0], trip_cause[3:1], trip_channel[5:4], setpoint_missing[6],
    // save_retry_ok[7], run_allowed[8], output_allowed[9], ack_accepted[10],
    // zero[15:11]
    output logic [15:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "over_temperature_trip_latch_macros.svh"

    logic [TEMP_W-1:0] trip_threshold;
    logic [TEMP_W-1:0] rearm_threshold;

    logic        in_valid_reg;
    otl_item_t   item_reg;
    logic        out_valid_reg;
    otl_result_t result_reg;
    otl_state_t  state_reg;
    otl_state_t  state_next;
    otl_result_t result_next;
    otl_item_t   item_in;
    logic        advance;

    otl_regs u_regs (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .trip_threshold  (trip_threshold),
        .rearm_threshold (rearm_threshold)
    );

    otl_eval #(
        .CHANNELS (CHANNELS)
    ) u_eval (
        .item            (item_reg),
        .state           (state_reg),
        .trip_threshold  (trip_threshold),
        .rearm_threshold (rearm_threshold),
        .state_next      (state_next),
        .result          (result_next)
    );

    always_comb
    begin
        item_in.action            = otl_action_t'(s_tuser);
        item_in.channel_count     = s_tdata[2:0];
        item_in.sample_valid_mask = s_tdata[6:3];
        item_in.temperature[0]    = s_tdata[22:7];
        item_in.temperature[1]    = s_tdata[38:23];
        item_in.temperature[2]    = s_tdata[54:39];
        item_in.temperature[3]    = s_tdata[70:55];
        item_in.scan_done         = s_tdata[71];
    end

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, result_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_reg <= item_in;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    `OTL_ASSERT_SAME(a_cause_matches_latch, 1'b1,
        state_reg.latched == (state_reg.cause != CAUSE_NONE))
    `OTL_ASSERT_SAME(a_ack_clears_all, out_valid_reg && result_reg.ack_accepted,
        !result_reg.trip_latched && result_reg.trip_cause == CAUSE_NONE)
    `OTL_ASSERT_SAME(a_run_is_not_latched, out_valid_reg,
        result_reg.run_allowed != result_reg.trip_latched)
    `OTL_ASSERT_NEXT(a_advance_gives_result, advance, out_valid_reg)

endmodule
